// File: rtl/core/largest_empty_square_finder_top_defines.svh
// Assertion macros shared by the largest empty square finder RTL.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_TOP_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LESF_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LESF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lesf_pkg.sv
// Package: widths, register indexes and shared types of the square finder.
package lesf_pkg;

  localparam int MaxColumns = 1024;
  localparam int MaxRows    = 1024;
  localparam int ValueW     = 11;
  localparam int CoordW     = 10;
  localparam int ColAddrW   = $clog2(MaxColumns);
  localparam int CfgIdxW    = 1;

  localparam logic [CfgIdxW-1:0] CfgRowCount    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgColumnCount = 1'b1;

  localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};

  // Position of one cell within the map, decided when the cell is accepted.
  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              first_row;
    logic              first_col;
    logic              map_end;
  } scan_t;

  // Status of the compute stage, seen by the top level.
  typedef struct packed {
    logic s1_valid;
    logic go;
    logic map_end;
  } stage_t;

  // Zero reads as one, anything above the limit saturates to it.
  function automatic logic [ValueW-1:0] eff_count(input logic [ValueW-1:0] cnt,
                                                  input logic [ValueW-1:0] limit);
    logic [ValueW-1:0] res;
    if (cnt == '0) begin
      res = ValueW'(1);
    end else if (cnt > limit) begin
      res = limit;
    end else begin
      res = cnt;
    end
    return res;
  endfunction

endpackage

// File: rtl/core/lesf_if.sv
// Interfaces: cell input channel and square result channel.
interface lesf_cell_if;
  logic valid;
  logic ready;
  logic cell_blocked;

  modport source (output valid, output cell_blocked, input ready);
  modport sink   (input valid, input cell_blocked, output ready);
endinterface

interface lesf_square_if;
  logic                        valid;
  logic                        ready;
  logic [lesf_pkg::ValueW-1:0] square_size;
  logic [lesf_pkg::CoordW-1:0] end_row;
  logic [lesf_pkg::CoordW-1:0] end_column;

  modport source (output valid, output square_size, output end_row, output end_column,
                  input ready);
  modport sink   (input valid, input square_size, input end_row, input end_column,
                  output ready);
endinterface

// File: rtl/core/largest_empty_square_finder_top.sv
// Largest empty square finder: takes one map cell per clock in row-major order (but
// for the stall below) and, after the last cell, returns the side and bottom-right
// corner of the largest all-empty square (first strict maximum wins, side 0 at corner
// 0,0 when the map has no empty cell). A cell is accepted every cycle but for that
// stall: it is registered with its position, the previous-row value is read from a
// 1024 x 11 single-port-read line store, and in the compute stage the three-way
// minimum is taken and written back. The result sits in an output register, loaded
// when the last cell retires from the compute stage; input stalls only while a
// finished map's result is still unread and the next map's last cell is waiting to
// retire. Row and column counts are taken from the size registers at once; zero reads
// as one and values above 1024 saturate. The line store needs no clearing after reset.
`include "largest_empty_square_finder_top_defines.svh"

module largest_empty_square_finder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lesf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lesf_pkg::ValueW-1:0]  cfg_wdata_i,
  lesf_cell_if.sink                    cell_i,
  lesf_square_if.source                square_o
);

  lesf_pkg::scan_t               scan;
  lesf_pkg::stage_t              stage;
  logic                          cell_accept;
  logic [lesf_pkg::ValueW-1:0]   up_data;
  logic                          wr_en;
  logic [lesf_pkg::ColAddrW-1:0] wr_addr;
  logic [lesf_pkg::ValueW-1:0]   wr_data;
  logic [lesf_pkg::ColAddrW-1:0] rd_addr;

  assign cell_i.ready = !stage.s1_valid || stage.go;
  assign cell_accept  = cell_i.valid && cell_i.ready;
  assign rd_addr      = scan.col[lesf_pkg::ColAddrW-1:0];

  lesf_scan_ctrl u_scan_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (cell_accept),
    .scan_o      (scan)
  );

  lesf_line_store u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (cell_accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (up_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  lesf_cell_unit u_cell_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (cell_accept),
    .scan_i    (scan),
    .blocked_i (cell_i.cell_blocked),
    .up_i      (up_data),
    .stage_o   (stage),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .square_o  (square_o)
  );

  `LESF_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, cell_accept, stage.s1_valid,
                    "accepted beat did not reach the compute stage")
  `LESF_ASSERT_NEXT(a_store_forward, clk_i, rst_ni,
                    cell_accept && wr_en && (wr_addr == rd_addr),
                    up_data == $past(wr_data), "line store read missed a same-cycle write")
  `LESF_ASSERT_IMPL(a_result_from_map_end, clk_i, rst_ni, $rose(square_o.valid),
                    $past(stage.go && stage.map_end),
                    "result beat raised without a retired map end")

endmodule

// File: rtl/core/lesf_scan_ctrl.sv
// Scan control: size registers and the row/column position of the next cell.
module lesf_scan_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lesf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lesf_pkg::ValueW-1:0]  cfg_wdata_i,
  input  logic                         accept_i,
  output lesf_pkg::scan_t              scan_o
);

  logic [lesf_pkg::ValueW-1:0] row_count_q;
  logic [lesf_pkg::ValueW-1:0] col_count_q;
  logic [lesf_pkg::CoordW-1:0] row_q, row_d;
  logic [lesf_pkg::CoordW-1:0] col_q, col_d;
  logic [lesf_pkg::ValueW-1:0] rows_eff;
  logic [lesf_pkg::ValueW-1:0] cols_eff;
  logic                        col_last;
  logic                        row_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= lesf_pkg::ValueW'(1);
      col_count_q <= lesf_pkg::ValueW'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == lesf_pkg::CfgRowCount) begin
        row_count_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == lesf_pkg::CfgColumnCount) begin
        col_count_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    rows_eff = lesf_pkg::eff_count(row_count_q, lesf_pkg::ValueW'(lesf_pkg::MaxRows));
    cols_eff = lesf_pkg::eff_count(col_count_q, lesf_pkg::ValueW'(lesf_pkg::MaxColumns));
    col_last = ({1'b0, col_q} + lesf_pkg::ValueW'(1)) >= cols_eff;
    row_last = ({1'b0, row_q} + lesf_pkg::ValueW'(1)) >= rows_eff;

    scan_o.row       = row_q;
    scan_o.col       = col_q;
    scan_o.first_row = (row_q == '0);
    scan_o.first_col = (col_q == '0);
    scan_o.map_end   = col_last && row_last;

    row_d = row_q;
    col_d = col_q;
    if (col_last) begin
      col_d = '0;
      row_d = row_last ? '0 : row_q + lesf_pkg::CoordW'(1);
    end else begin
      col_d = col_q + lesf_pkg::CoordW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// File: rtl/core/lesf_line_store.sv
// Line store: previous row of square sides, one read and one write port.
module lesf_line_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [lesf_pkg::ColAddrW-1:0]  rd_addr_i,
  output logic [lesf_pkg::ValueW-1:0]    rd_data_o,
  input  logic                           wr_en_i,
  input  logic [lesf_pkg::ColAddrW-1:0]  wr_addr_i,
  input  logic [lesf_pkg::ValueW-1:0]    wr_data_i
);

  logic [lesf_pkg::ValueW-1:0] mem [lesf_pkg::MaxColumns];
  logic [lesf_pkg::ValueW-1:0] rd_q;
  logic [lesf_pkg::ValueW-1:0] fwd_data_q;
  logic                        fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Forward a write that lands on the entry being read in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

// File: rtl/core/lesf_cell_unit.sv
// Cell unit: square side per cell, best-square tracking and the result register.
module lesf_cell_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  lesf_pkg::scan_t                scan_i,
  input  logic                           blocked_i,
  input  logic [lesf_pkg::ValueW-1:0]    up_i,
  output lesf_pkg::stage_t               stage_o,
  output logic                           wr_en_o,
  output logic [lesf_pkg::ColAddrW-1:0]  wr_addr_o,
  output logic [lesf_pkg::ValueW-1:0]    wr_data_o,
  lesf_square_if.source                  square_o
);

  logic                        s1_valid_q;
  lesf_pkg::scan_t             s1_scan_q;
  logic                        s1_blocked_q;
  logic [lesf_pkg::ValueW-1:0] left_q;
  logic [lesf_pkg::ValueW-1:0] diag_q;
  logic [lesf_pkg::ValueW-1:0] best_size_q;
  logic [lesf_pkg::CoordW-1:0] best_row_q;
  logic [lesf_pkg::CoordW-1:0] best_col_q;
  logic                        out_valid_q;
  logic [lesf_pkg::ValueW-1:0] out_size_q;
  logic [lesf_pkg::CoordW-1:0] out_row_q;
  logic [lesf_pkg::CoordW-1:0] out_col_q;

  logic [lesf_pkg::ValueW-1:0] up;
  logic [lesf_pkg::ValueW-1:0] left;
  logic [lesf_pkg::ValueW-1:0] diag;
  logic [lesf_pkg::ValueW-1:0] min_lu;
  logic [lesf_pkg::ValueW-1:0] min_all;
  logic [lesf_pkg::ValueW-1:0] value;
  logic                        better;
  logic                        go;

  always_comb begin
    // Neighbors outside the map count as zero.
    up      = s1_scan_q.first_row ? '0 : up_i;
    left    = s1_scan_q.first_col ? '0 : left_q;
    diag    = (s1_scan_q.first_col || s1_scan_q.first_row) ? '0 : diag_q;
    min_lu  = (left < up) ? left : up;
    min_all = (min_lu < diag) ? min_lu : diag;
    if (s1_blocked_q) begin
      value = '0;
    end else if (min_all == lesf_pkg::ValueMax) begin
      value = lesf_pkg::ValueMax;
    end else begin
      value = min_all + lesf_pkg::ValueW'(1);
    end
    better = value > best_size_q;
    // Hold the last cell of a map until the result slot is free.
    go = s1_valid_q && (!s1_scan_q.map_end || !out_valid_q || square_o.ready);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_scan_q    <= scan_i;
      s1_blocked_q <= blocked_i;
    end
    if (go && s1_scan_q.map_end) begin
      out_size_q <= better ? value : best_size_q;
      out_row_q  <= better ? s1_scan_q.row : best_row_q;
      out_col_q  <= better ? s1_scan_q.col : best_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
      end else if (go) begin
        s1_valid_q <= 1'b0;
      end

      if (go) begin
        left_q <= value;
        diag_q <= up;
        if (s1_scan_q.map_end) begin
          best_size_q <= '0;
          best_row_q  <= '0;
          best_col_q  <= '0;
        end else if (better) begin
          best_size_q <= value;
          best_row_q  <= s1_scan_q.row;
          best_col_q  <= s1_scan_q.col;
        end
      end

      if (go && s1_scan_q.map_end) begin
        out_valid_q <= 1'b1;
      end else if (square_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign wr_en_o   = go;
  assign wr_addr_o = s1_scan_q.col[lesf_pkg::ColAddrW-1:0];
  assign wr_data_o = value;

  assign stage_o.s1_valid = s1_valid_q;
  assign stage_o.go       = go;
  assign stage_o.map_end  = s1_scan_q.map_end;

  assign square_o.valid       = out_valid_q;
  assign square_o.square_size = out_size_q;
  assign square_o.end_row     = out_row_q;
  assign square_o.end_column  = out_col_q;

endmodule
